[design/bmffa_pkg.sv]
`default_nettype none

package bmffa_pkg;

  // Default heap depth in bytes and the heap size taken at reset
  localparam int HEAP_BYTES_DEF = 1024;
  localparam int RESET_SIZE     = 1024;

  // Field widths fixed by the stream format
  localparam int SizeW   = 11;
  localparam int OffsetW = 10;

  // One status entry per heap byte: bit 0 busy, bit 1 busy and not block end
  typedef logic [1:0] map_entry_t;

  localparam map_entry_t MAP_FREE = 2'd0;
  localparam map_entry_t MAP_END  = 2'd1;
  localparam map_entry_t MAP_MORE = 2'd3;

  // Request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Response codes
  typedef logic [1:0] resp_code_t;

  localparam resp_code_t RESP_ALLOCATED = 2'd0;
  localparam resp_code_t RESP_FAILED    = 2'd1;
  localparam resp_code_t RESP_FREED     = 2'd2;
  localparam resp_code_t RESP_IGNORED   = 2'd3;

  // Control strobes from the sequencer to the map memory
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    map_entry_t wr_data;
  } map_ctl_t;

endpackage

`default_nettype wire

[design/bmffa_map.sv]
`default_nettype none

module bmffa_map #(
  parameter int Depth = bmffa_pkg::HEAP_BYTES_DEF,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire                      clk_i,
  input  wire bmffa_pkg::map_ctl_t ctl_i,
  input  wire [AddrW-1:0]          wr_addr_i,
  input  wire [AddrW-1:0]          rd_addr_i,
  output bmffa_pkg::map_entry_t    rd_data_o
);

  import bmffa_pkg::*;

  map_entry_t mem_q [Depth];
  map_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= ctl_i.wr_data;
    end
  end

  // Registered read, one address per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[design/byte_map_first_fit_allocator_core.sv]
`default_nettype none

// First-fit byte-map heap allocator.
// Requests come in on the s_axis channel: tuser carries the kind (allocate or
// free), tdata the request size and the block offset. Each request yields one
// response on the m_axis channel: tuser carries the response code, tdata the
// granted offset (zero unless the allocation succeeded). The cfg channel
// writes the heap size in bytes; a write clamps it to 1..HEAP_BYTES and
// clears the whole map.
// The map walk runs on one shared position counter and one single-port-read
// map memory, one heap byte per cycle:
//   allocate: search for a free run from the hint, then mark the block,
//             then move the hint past busy bytes when the block sat on it;
//   free:     clear marks up to the block end or the last heap byte;
//             rejected requests of either kind go straight to the response.
// One request is in flight at a time; s_axis_tready_o is high only between
// requests. A new request is taken while the previous response still waits
// in the output register.
// After reset and after each heap size write, a clearing pass over the map
// zeroes every entry, during which no request is taken (cfg writes still
// are). If the receiver stalls, the finished response waits and the block
// holds before loading the next one.

module byte_map_first_fit_allocator_core #(
  parameter int HEAP_BYTES = bmffa_pkg::HEAP_BYTES_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // request: [10:0] request_size, [21:11] block_offset, zero pad
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  wire [23:0]                    s_axis_tdata_i,
  // request: [0] operation
  input  wire [0:0]                     s_axis_tuser_i,
  // response: [9:0] granted_offset, zero pad
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o,
  // response: [1:0] status
  output logic [1:0]                    m_axis_tuser_o,
  // heap size write
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [bmffa_pkg::SizeW-1:0]    cfg_data_i
);

  import bmffa_pkg::*;

  localparam int AddrW = $clog2(HEAP_BYTES);
  localparam int PosW  = $clog2(HEAP_BYTES + 1);
  localparam int ExtW  = (PosW > SizeW) ? PosW : SizeW;

  localparam logic [ExtW-1:0] HeapMax  = ExtW'(HEAP_BYTES);
  localparam logic [ExtW-1:0] LastAddr = ExtW'(HEAP_BYTES - 1);
  localparam logic [ExtW-1:0] ResetHeap =
    (RESET_SIZE > HEAP_BYTES) ? ExtW'(HEAP_BYTES) : ExtW'(RESET_SIZE);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_HINT  = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [ExtW-1:0]    pos_q, pos_d;
  logic [ExtW-1:0]    start_q, start_d;
  logic [ExtW-1:0]    end_q, end_d;
  logic [ExtW-1:0]    found_q, found_d;
  logic [ExtW-1:0]    hint_q, hint_d;
  logic [ExtW-1:0]    heap_q, heap_d;
  logic [ExtW-1:0]    req_q, req_d;
  logic               walk_hint_q, walk_hint_d;
  resp_code_t         res_status_q, res_status_d;
  logic [OffsetW-1:0] res_offset_q, res_offset_d;
  logic               m_valid_q, m_valid_d;
  resp_code_t         m_status_q, m_status_d;
  logic [OffsetW-1:0] m_offset_q, m_offset_d;

  map_ctl_t           map_ctl;
  logic [AddrW-1:0]   map_wr_addr;
  logic [AddrW-1:0]   map_rd_addr;
  map_entry_t         map_rd_data;

  logic [ExtW-1:0]    in_req;
  logic [ExtW-1:0]    in_at;
  logic [ExtW-1:0]    cfg_ext;
  logic [ExtW-1:0]    pos_inc;
  logic [ExtW-1:0]    found_inc;
  logic [ExtW-1:0]    start_now;
  logic               in_heap;

  assign in_req    = ExtW'(s_axis_tdata_i[SizeW-1:0]);
  assign in_at     = ExtW'(s_axis_tdata_i[2*SizeW-1:SizeW]);
  assign cfg_ext   = ExtW'(cfg_data_i);
  assign pos_inc   = pos_q + ExtW'(1);
  assign found_inc = found_q + ExtW'(1);
  assign in_heap   = pos_q < heap_q;
  assign start_now = (found_q == '0) ? pos_q : start_q;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    start_d      = start_q;
    end_d        = end_q;
    found_d      = found_q;
    hint_d       = hint_q;
    heap_d       = heap_q;
    req_d        = req_q;
    walk_hint_d  = walk_hint_q;
    res_status_d = res_status_q;
    res_offset_d = res_offset_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_offset_d   = m_offset_q;

    map_ctl.rd_en   = 1'b0;
    map_ctl.wr_en   = 1'b0;
    map_ctl.wr_data = MAP_FREE;
    map_wr_addr     = pos_q[AddrW-1:0];
    // read one byte ahead so the walk keeps one byte per cycle
    map_rd_addr     = pos_inc[AddrW-1:0];

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        map_ctl.wr_en = 1'b1;
        pos_d = pos_inc;
        if (pos_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_offset_d = '0;
          if (s_axis_tuser_i[0] == OP_FREE) begin
            if (in_at >= heap_q) begin
              res_status_d = RESP_IGNORED;
              state_d = S_RESP;
            end else begin
              map_ctl.rd_en = 1'b1;
              map_rd_addr = in_at[AddrW-1:0];
              pos_d = in_at;
              if (in_at < hint_q) begin
                hint_d = in_at;
              end
              state_d = S_FREE;
            end
          end else begin
            if (in_req == '0 || in_req > heap_q || hint_q >= heap_q) begin
              res_status_d = RESP_FAILED;
              state_d = S_RESP;
            end else begin
              map_ctl.rd_en = 1'b1;
              map_rd_addr = hint_q[AddrW-1:0];
              pos_d = hint_q;
              start_d = hint_q;
              found_d = '0;
              req_d = in_req;
              state_d = S_SRCH;
            end
          end
        end
      end

      // rd data holds the entry at pos_q; fail past the heap end, else extend or restart the free run
      S_SRCH: begin
        map_ctl.rd_en = 1'b1;
        pos_d = pos_inc;
        if (!in_heap) begin
          res_status_d = RESP_FAILED;
          state_d = S_RESP;
        end else if (!map_rd_data[0]) begin
          start_d = start_now;
          found_d = found_inc;
          if (found_inc == req_q) begin
            end_d = pos_q;
            pos_d = start_now;
            walk_hint_d = (start_now == hint_q);
            state_d = S_MARK;
          end
        end else begin
          found_d = '0;
        end
      end

      // write the block; the read register keeps the byte after the block
      S_MARK: begin
        map_ctl.wr_en = 1'b1;
        map_ctl.wr_data = (pos_q == end_q) ? MAP_END : MAP_MORE;
        pos_d = pos_inc;
        if (pos_q == end_q) begin
          res_status_d = RESP_ALLOCATED;
          res_offset_d = start_q[OffsetW-1:0];
          state_d = walk_hint_q ? S_HINT : S_RESP;
        end
      end

      // advance the hint past busy bytes
      S_HINT: begin
        map_ctl.rd_en = 1'b1;
        if (in_heap && map_rd_data[0]) begin
          pos_d = pos_inc;
        end else begin
          hint_d = pos_q;
          state_d = S_RESP;
        end
      end

      // drop marks up to the end of the block or the last heap byte
      S_FREE: begin
        map_ctl.rd_en = 1'b1;
        map_ctl.wr_en = 1'b1;
        if (map_rd_data[1] && pos_inc < heap_q) begin
          pos_d = pos_inc;
        end else begin
          res_status_d = RESP_FREED;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_offset_d = res_offset_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
        pos_d   = '0;
      end
    endcase

    // heap size write: clamp, reset the hint, restart the clearing pass
    if (cfg_valid_i) begin
      if (cfg_ext == '0) begin
        heap_d = ExtW'(1);
      end else if (cfg_ext > HeapMax) begin
        heap_d = HeapMax;
      end else begin
        heap_d = cfg_ext;
      end
      hint_d  = '0;
      pos_d   = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      pos_q     <= '0;
      hint_q    <= '0;
      heap_q    <= ResetHeap;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      hint_q    <= hint_d;
      heap_q    <= heap_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q      <= start_d;
    end_q        <= end_d;
    found_q      <= found_d;
    req_q        <= req_d;
    walk_hint_q  <= walk_hint_d;
    res_status_q <= res_status_d;
    res_offset_q <= res_offset_d;
    m_status_q   <= m_status_d;
    m_offset_q   <= m_offset_d;
  end

  bmffa_map #(
    .Depth(HEAP_BYTES)
  ) u_map (
    .clk_i     (clk_i),
    .ctl_i     (map_ctl),
    .wr_addr_i (map_wr_addr),
    .rd_addr_i (map_rd_addr),
    .rd_data_o (map_rd_data)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = 16'(m_offset_q);
  assign m_axis_tuser_o  = m_status_q;
  assign cfg_ready_o     = 1'b1;

`ifndef SYNTHESIS
  a_resp_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_RESP)
    else $error("response raised outside the response state");

  a_hint_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> hint_q <= heap_q)
    else $error("free hint beyond heap size");

  a_heap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_q != '0 && heap_q <= HeapMax)
    else $error("heap size out of range");

  a_run_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH |-> found_q < req_q)
    else $error("search run reached request size without marking");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_status_q != RESP_ALLOCATED |-> m_offset_q == '0)
    else $error("nonzero offset on a response without allocation");
`endif

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
  import bmffa_pkg::*;

  // Stall the watchdog can tolerate: the worst allocate walk plus the clearing
  // pass after a size write, taken several times over
  localparam int QUIET_LIMIT = 20000;

  // One pending request as the driver sees it
  typedef struct {
    logic        op;
    logic [10:0] size;
    logic [10:0] offset;
    bit          pick_live;  // resolve offset to a live block start at load time
  } req_t;

  // One awaited response
  typedef struct {
    resp_code_t  status;
    logic [9:0]  offset;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [23:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [10:0] cfg_data_i = '0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [15:0] m_axis_tdata_o;
  wire  [1:0]  m_axis_tuser_o;
  wire         cfg_ready_o;

  byte_map_first_fit_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow of the heap: byte map, first-free hint and heap size in use
  map_entry_t  heap_map [HEAP_BYTES_DEF];
  int unsigned hint;
  int unsigned heap_len;

  req_t   req_q [$];    // requests waiting for the driver
  grant_t grant_q [$];  // responses the block still owes
  req_t   load_req;
  grant_t want;

  int gap_pct = 12;     // percent of cycles the request side idles
  int stall_pct = 12;   // percent of cycles the response side stalls
  int err_cnt = 0;
  int quiet_cycles = 0;

  int unsigned heap_plan [9];
  int          count_plan [9];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit busy_at(input int unsigned i);
    return i < heap_len && heap_map[i][0];
  endfunction

  // Apply one request to the shadow heap and return the response it earns
  function automatic grant_t predict_grant(input req_t r);
    grant_t      g;
    int unsigned pos, found, start, last, i;
    g.status = RESP_FAILED;
    g.offset = '0;
    if (r.op == OP_FREE) begin
      if (r.offset >= heap_len) begin
        g.status = RESP_IGNORED;
        return g;
      end
      // Walk to the block end; stop at the last heap byte if no end mark shows up
      last = r.offset;
      while (heap_map[last][1] && last + 1 < heap_len) last++;
      for (i = r.offset; i <= last; i++) heap_map[i] = MAP_FREE;
      if (r.offset < hint) hint = r.offset;
      g.status = RESP_FREED;
      return g;
    end
    if (r.size == 0 || r.size > heap_len || hint >= heap_len) return g;
    pos = hint;
    start = hint;
    found = 0;
    // First fit: restart the run after every busy stretch
    while (found != r.size) begin
      if (pos < heap_len && !busy_at(pos)) begin
        found++;
        pos++;
      end else begin
        found = 0;
        while (busy_at(pos)) pos++;
        if (pos >= heap_len) return g;
        start = pos;
      end
    end
    for (i = start; i + 1 < pos; i++) heap_map[i] = MAP_MORE;
    heap_map[pos - 1] = MAP_END;
    // Move the hint only when the block sat right on it
    if (start == hint) begin
      while (busy_at(pos)) pos++;
      hint = pos;
    end
    g.status = RESP_ALLOCATED;
    g.offset = start[9:0];
    return g;
  endfunction

  // Pick a live block start, sometimes the byte after it, so frees hit real blocks
  function automatic logic [10:0] pick_block_start();
    int unsigned starts [$];
    int unsigned at;
    for (int unsigned i = 0; i < heap_len; i++) begin
      if (heap_map[i][0] && (i == 0 || !heap_map[i - 1][1])) starts.push_back(i);
    end
    if (starts.size() == 0) return 11'($urandom_range(0, heap_len - 1));
    at = starts[$urandom_range(0, starts.size() - 1)];
    if ($urandom_range(99) < 20 && at + 1 < heap_len) at++;
    return 11'(at);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
  endtask

  task automatic push_req(input logic op, input int unsigned size, input int unsigned offset);
    req_t r;
    r.op = op;
    r.size = 11'(size);
    r.offset = 11'(offset);
    r.pick_live = 0;
    req_q.push_back(r);
  endtask

  // Hold until every request went out and every response came back
  task automatic drain();
    while (req_q.size() != 0 || s_axis_tvalid_i || grant_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the heap size; the block clears its map, so clear the shadow too
  task automatic write_heap_size(input logic [10:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    heap_len = (v == 0) ? 1 : (v > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : v;
    foreach (heap_map[i]) heap_map[i] = MAP_FREE;
    hint = 0;
  endtask

  // Mostly sensible allocates and frees of live blocks, the rest noise
  task automatic queue_random(input int n);
    req_t        r;
    int          roll;
    int unsigned cap;
    cap = (heap_len / 4 == 0) ? 1 : heap_len / 4;
    repeat (n) begin
      r.size = 11'($urandom_range(0, 2047));
      r.offset = 11'($urandom_range(0, 2047));
      r.pick_live = 0;
      roll = $urandom_range(99);
      if (roll < 55) begin
        r.op = OP_ALLOC;
        roll = $urandom_range(99);
        if (roll < 75) r.size = 11'($urandom_range(1, cap));
        else if (roll < 82) r.size = '0;
        else if (roll < 90) r.size = 11'(heap_len + $urandom_range(0, 2));
      end else begin
        r.op = OP_FREE;
        roll = $urandom_range(99);
        if (roll < 70) r.pick_live = 1;
        else if (roll < 88) r.offset = 11'($urandom_range(0, heap_len - 1));
      end
      req_q.push_back(r);
    end
  endtask

  // Request driver: load the next request once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        load_req = req_q.pop_front();
        if (load_req.pick_live) load_req.offset = pick_block_start();
        grant_q.push_back(predict_grant(load_req));
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {2'b00, load_req.offset, load_req.size};
        s_axis_tuser_i <= load_req.op;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Response monitor: compare against the oldest awaited response, then draw ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (grant_q.size() == 0) begin
          flag_mismatch("unexpected response status", 0, m_axis_tuser_o);
        end else begin
          want = grant_q.pop_front();
          if (m_axis_tuser_o !== want.status) flag_mismatch("status", want.status, m_axis_tuser_o);
          if (m_axis_tdata_o[9:0] !== want.offset) begin
            flag_mismatch("granted_offset", want.offset, m_axis_tdata_o[9:0]);
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if no channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    heap_len = RESET_SIZE;
    hint = 0;
    foreach (heap_map[i]) heap_map[i] = MAP_FREE;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full heap after reset: zero, oversize, ignored frees, whole-heap grant, full, whole-block free
    push_req(OP_ALLOC, 0, 2047);
    push_req(OP_ALLOC, 1025, 0);
    push_req(OP_ALLOC, 2047, 1024);
    push_req(OP_FREE, 2047, 1024);
    push_req(OP_FREE, 0, 2047);
    push_req(OP_ALLOC, 1024, 0);
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_FREE, 0, 0);
    drain();

    // Tiny heap: fill, no-fit search, hint moves, frees of inner, end and free bytes
    write_heap_size(8);
    push_req(OP_ALLOC, 3, 0);
    push_req(OP_ALLOC, 2, 0);
    push_req(OP_ALLOC, 3, 0);
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_FREE, 0, 3);
    push_req(OP_ALLOC, 3, 0);
    push_req(OP_ALLOC, 2, 0);
    push_req(OP_FREE, 0, 6);
    push_req(OP_FREE, 0, 1);
    push_req(OP_FREE, 0, 4);
    push_req(OP_FREE, 0, 4);
    push_req(OP_ALLOC, 2, 0);
    push_req(OP_FREE, 0, 3);
    push_req(OP_ALLOC, 4, 0);
    drain();

    // Zero size write acts as a one-byte heap
    write_heap_size(0);
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_FREE, 0, 0);
    drain();

    // Random phases over several heap sizes, saturated and extreme ones included
    heap_plan = '{2047, 16, 5, 64, 1023, 37, $urandom_range(2, 200), 1024, 1};
    count_plan = '{12, 26, 22, 26, 12, 22, 22, 13, 10};
    for (int p = 0; p < 9; p++) begin
      write_heap_size(11'(heap_plan[p]));
      gap_pct = (p == 3) ? 0 : 12;
      stall_pct = (p == 3) ? 0 : 12;
      queue_random(count_plan[p]);
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/bmffa_pkg.sv
design/bmffa_map.sv
design/byte_map_first_fit_allocator_core.sv
dv/tb_top.sv
